### hdl/assert_macros.svh
// Assertion macros shared by the CSR trap unit sources.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, held off while reset is high.
`define CHK_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs through reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_CLK(label, clk, rst, prop, msg)
`define CHK_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hdl/mcsr_pkg.sv
// Types and constants of the machine-mode CSR trap unit.
package mcsr_pkg;

  localparam int XLEN_DEF = 64;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 12;
  localparam int OP_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_RW   = 3'd0,
    OP_RS   = 3'd1,
    OP_RC   = 3'd2,
    OP_TRAP = 3'd3,
    OP_RET  = 3'd4
  } op_t;

  localparam logic [ADDR_W-1:0] CSR_MSTATUS = 12'h300;
  localparam logic [ADDR_W-1:0] CSR_MIE     = 12'h304;
  localparam logic [ADDR_W-1:0] CSR_MTVEC   = 12'h305;
  localparam logic [ADDR_W-1:0] CSR_MEPC    = 12'h341;
  localparam logic [ADDR_W-1:0] CSR_MCAUSE  = 12'h342;
  localparam logic [ADDR_W-1:0] CSR_MIP     = 12'h344;

  // mstatus bit positions
  localparam int MIE_BIT  = 3;
  localparam int MPIE_BIT = 7;
  localparam int MPP_LO   = 11;
  localparam int MPP_HI   = 12;
  localparam logic [1:0] MPP_MACHINE = 2'b11;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] cause;
    logic [DATA_W-1:0] pc;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              bad;
  } rsp_t;

endpackage

### hdl/mcsr_file.sv
// CSR storage and single-pass operation logic of the trap unit.
`include "assert_macros.svh"

module mcsr_file
  import mcsr_pkg::*;
#(
  parameter int XLEN = XLEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic commit,
  input  req_t req,
  output rsp_t rsp
);

  logic [XLEN-1:0] mstatus, mstatus_next;
  logic [XLEN-1:0] mtvec, mtvec_next;
  logic [XLEN-1:0] mepc, mepc_next;
  logic [XLEN-1:0] mcause, mcause_next;
  logic [XLEN-1:0] mie, mie_next;
  logic [XLEN-1:0] mip, mip_next;

  logic [XLEN-1:0] opnd, old_val, new_val, value;
  logic            hit, bad;

  assign opnd = req.operand[XLEN-1:0];

  // Read port for the CSR instructions.
  always_comb begin
    hit     = 1'b1;
    old_val = '0;
    unique case (req.addr)
      CSR_MSTATUS: old_val = mstatus;
      CSR_MTVEC:   old_val = mtvec;
      CSR_MEPC:    old_val = mepc;
      CSR_MCAUSE:  old_val = mcause;
      CSR_MIE:     old_val = mie;
      CSR_MIP:     old_val = mip;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    case (req.op)
      OP_RS:   new_val = old_val | opnd;
      OP_RC:   new_val = old_val & ~opnd;
      default: new_val = opnd;
    endcase
  end

  always_comb begin
    mstatus_next = mstatus;
    mtvec_next   = mtvec;
    mepc_next    = mepc;
    mcause_next  = mcause;
    mie_next     = mie;
    mip_next     = mip;
    value        = '0;
    bad          = 1'b0;
    unique case (req.op) inside
      OP_RW, OP_RS, OP_RC: begin
        bad = !hit;
        if (hit) begin
          value = old_val;
        end
        unique case (req.addr)
          CSR_MSTATUS: mstatus_next = new_val;
          CSR_MTVEC:   mtvec_next   = new_val;
          CSR_MEPC:    mepc_next    = new_val;
          CSR_MCAUSE:  mcause_next  = new_val;
          CSR_MIE:     mie_next     = new_val;
          CSR_MIP:     mip_next     = new_val;
          default: ;
        endcase
      end
      OP_TRAP: begin
        mepc_next              = req.pc[XLEN-1:0];
        mcause_next            = req.cause[XLEN-1:0];
        mstatus_next[MPIE_BIT] = mstatus[MIE_BIT];
        mstatus_next[MIE_BIT]  = 1'b0;
        value                  = mtvec;
      end
      OP_RET: begin
        mstatus_next[MIE_BIT]       = mstatus[MPIE_BIT];
        mstatus_next[MPIE_BIT]      = 1'b1;
        mstatus_next[MPP_HI:MPP_LO] = MPP_MACHINE;
        // interrupts resume at mepc, exceptions past the faulting instruction
        value = mcause[XLEN-1] ? mepc : mepc + XLEN'(4);
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.value             = '0;
    rsp.value[XLEN-1:0]   = value;
    rsp.bad               = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstatus <= '0;
      mtvec   <= '0;
      mepc    <= '0;
      mcause  <= '0;
      mie     <= '0;
      mip     <= '0;
    end else if (commit) begin
      mstatus <= mstatus_next;
      mtvec   <= mtvec_next;
      mepc    <= mepc_next;
      mcause  <= mcause_next;
      mie     <= mie_next;
      mip     <= mip_next;
    end
  end

  `CHK_CLK(a_trap_clears_mie, clk, rst, commit && req.op == OP_TRAP |=> !mstatus[MIE_BIT], "trap left MIE set")
  `CHK_CLK(a_ret_sets_mpp, clk, rst, commit && req.op == OP_RET |=> mstatus[MPP_HI:MPP_LO] == MPP_MACHINE && mstatus[MPIE_BIT], "return did not set MPP and MPIE")
  `CHK_CLK(a_hold_when_idle, clk, rst, !commit |=> $stable(mstatus) && $stable(mepc) && $stable(mcause), "CSR changed without a committed operation")
  `CHK_CLK(a_bad_reads_zero, clk, rst, rsp.bad |-> rsp.value == '0 && !hit, "bad address returned data")

endmodule

### hdl/machine_mode_csr_trap_unit.sv
// Top level of the machine-mode CSR trap unit: stream ports and pipeline registers.
//
//  channel | dir | tdata                                         | tuser
//  s_*     | in  | csr_address, operand, trap_cause, trap_pc     | operation
//  m_*     | out | result_value                                  | bad_address
//
// One operation per cycle unless the output register stalls: a beat lands in the
// input register, the CSR logic runs in one pass and updates the CSRs as the result
// moves to the output register, so the next beat sees the new state.
// The single output register stalls the input register only while m_tready is low.
// rst (synchronous) clears all CSRs to zero and empties both registers.
`include "assert_macros.svh"

module machine_mode_csr_trap_unit
  import mcsr_pkg::*;
#(
  parameter int XLEN = XLEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // [11:0] csr_address, [75:12] operand, [139:76] trap_cause, [203:140] trap_pc, [207:204] zero
  input  logic [207:0]  s_tdata,
  // [2:0] operation
  input  logic [OP_W-1:0] s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // [63:0] result_value
  output logic [DATA_W-1:0] m_tdata,
  // [0] bad_address
  output logic [0:0]    m_tuser
);

  logic in_valid;
  req_t in_req;
  rsp_t rsp;
  logic advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.op      <= op_t'(s_tuser);
      in_req.addr    <= s_tdata[11:0];
      in_req.operand <= s_tdata[75:12];
      in_req.cause   <= s_tdata[139:76];
      in_req.pc      <= s_tdata[203:140];
    end
  end

  mcsr_file #(
    .XLEN(XLEN)
  ) u_file (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (in_req),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= rsp.value;
      m_tuser[0] <= rsp.bad;
    end
  end

  `CHK_CLK(a_advance_fills_out, clk, rst, advance |=> m_tvalid, "result beat lost")
  `CHK_CLK(a_in_holds, clk, rst, in_valid && !advance |=> in_valid, "input register dropped a beat")
  `CHK_ALWAYS(a_reset_empties, clk, rst |=> !m_tvalid && !in_valid, "registers not empty after reset")

endmodule
